// File: src/assert_macros.svh
// Assertion macros shared by the matcher and top-level RTL files of the keyword duty controller.
// Define NO_ASSERTIONS to compile every use away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication failed");

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: src/ukmdc_pkg.sv
// Package for the keyword duty controller: types, constants, keyword tables
// and the per-keyword prefix advance function. No dependencies.
package ukmdc_pkg;

    localparam int KEY_NUM       = 7;
    localparam int KEY_MAX       = 8;
    localparam int PROG_W        = 4;
    localparam int DUTY_W        = 16;
    localparam int CH_NUM        = 4;
    localparam int BYTE_W        = 8;
    localparam int CFG_IDX_W     = 2;
    localparam int MSG_LIMIT_DEF = 99;

    localparam logic [DUTY_W-1:0] DUTY_STEP_RST   = 16'd100;
    localparam logic [DUTY_W-1:0] UPPER_GUARD_RST = 16'd999;
    localparam logic [DUTY_W-1:0] LOWER_GUARD_RST = 16'd100;
    localparam logic [DUTY_W-1:0] TURN_LEVEL_RST  = 16'd999;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DUTY_STEP   = 2'd0,
        REG_UPPER_GUARD = 2'd1,
        REG_LOWER_GUARD = 2'd2,
        REG_TURN_LEVEL  = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        CMD_NONE      = 3'd0,
        CMD_FWD_UP    = 3'd1,
        CMD_FWD_DOWN  = 3'd2,
        CMD_STOP      = 3'd3,
        CMD_BACK_UP   = 3'd4,
        CMD_BACK_DOWN = 3'd5,
        CMD_RIGHT     = 3'd6,
        CMD_LEFT      = 3'd7
    } cmd_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty_step;
        logic [DUTY_W-1:0] upper_guard;
        logic [DUTY_W-1:0] lower_guard;
        logic [DUTY_W-1:0] turn_level;
    } cfg_t;

    typedef logic [CH_NUM-1:0][DUTY_W-1:0] duty_t;

    // request moving from input register to result register
    typedef struct packed {
        logic fire;
        logic eom;
    } ctl_t;

    typedef struct packed {
        logic [KEY_NUM-1:0] found;
        logic               dropped;
    } match_t;

    typedef struct packed {
        cmd_t  command;
        logic  applied;
        duty_t duty;
    } res_t;

    // AVANCE+, AVANCE-, STOP, ARRIERE+, ARRIERE-, DROITE, GAUCHE
    localparam logic [BYTE_W-1:0] KEY_CHARS [KEY_NUM][KEY_MAX] = '{
        '{"A", "V", "A", "N", "C", "E", "+", 8'h00},
        '{"A", "V", "A", "N", "C", "E", "-", 8'h00},
        '{"S", "T", "O", "P", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"A", "R", "R", "I", "E", "R", "E", "+"},
        '{"A", "R", "R", "I", "E", "R", "E", "-"},
        '{"D", "R", "O", "I", "T", "E", 8'h00, 8'h00},
        '{"G", "A", "U", "C", "H", "E", 8'h00, 8'h00}
    };

    localparam logic [PROG_W-1:0] KEY_LEN [KEY_NUM] = '{
        4'd7, 4'd7, 4'd4, 4'd8, 4'd8, 4'd6, 4'd6
    };

    // Longest keyword prefix that ends the text (matched prefix, then c).
    function automatic logic [PROG_W-1:0] key_advance(
        input logic [2:0]        w,
        input logic [PROG_W-1:0] p,
        input logic [BYTE_W-1:0] c
    );
        int                n;
        int                pp;
        int                l;
        int                i;
        int                j;
        logic              ok;
        logic              hit;
        logic [PROG_W-1:0] res;
        n   = int'(KEY_LEN[w]);
        pp  = (int'(p) > n) ? n : int'(p);
        res = '0;
        hit = 1'b0;
        for (l = KEY_MAX; l >= 1; l--)
        begin
            if (!hit && l <= pp + 1 && l <= n)
            begin
                ok = (KEY_CHARS[w][3'(l - 1)] == c);
                for (i = 0; i < KEY_MAX - 1; i++)
                begin
                    if (i < l - 1)
                    begin
                        j = pp + 1 - l + i;
                        if (KEY_CHARS[w][j[2:0]] != KEY_CHARS[w][i[2:0]])
                        begin
                            ok = 1'b0;
                        end
                    end
                end
                if (ok)
                begin
                    res = PROG_W'(l);
                    hit = 1'b1;
                end
            end
        end
        return res;
    endfunction

endpackage

// File: src/ukmdc_matcher.sv
// Message store bookkeeping and the seven incremental keyword matchers.
// Depends on ukmdc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ukmdc_matcher #(
    parameter int MSG_LIMIT = ukmdc_pkg::MSG_LIMIT_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  ukmdc_pkg::ctl_t              ctl,
    input  logic [ukmdc_pkg::BYTE_W-1:0] rx_byte,
    output ukmdc_pkg::match_t            status
);
    import ukmdc_pkg::*;

    localparam int LEN_W = $clog2(MSG_LIMIT + 1);
    localparam logic [LEN_W-1:0] LIMIT = LEN_W'(MSG_LIMIT);

    logic [LEN_W-1:0]   len_reg, len_next;
    logic               term_reg, term_next;
    logic [PROG_W-1:0]  prog_reg [KEY_NUM];
    logic [PROG_W-1:0]  prog_next [KEY_NUM];
    logic [KEY_NUM-1:0] found_reg, found_next;
    logic               full;

    assign full = (len_reg >= LIMIT);

    always_comb
    begin
        len_next   = len_reg;
        term_next  = term_reg;
        prog_next  = prog_reg;
        found_next = found_reg;
        if (ctl.fire)
        begin
            if (ctl.eom)
            begin
                len_next   = '0;
                term_next  = 1'b0;
                found_next = '0;
                for (int w = 0; w < KEY_NUM; w++)
                begin
                    prog_next[w] = '0;
                end
            end
            else if (!full)
            begin
                len_next  = len_reg + LEN_W'(1);
                term_next = term_reg | (rx_byte == '0);
                if (!term_next)
                begin
                    for (int w = 0; w < KEY_NUM; w++)
                    begin
                        prog_next[w] = key_advance(3'(w), prog_reg[w], rx_byte);
                        if (prog_next[w] >= KEY_LEN[w])
                        begin
                            found_next[w] = 1'b1;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= '0;
            term_reg  <= 1'b0;
            found_reg <= '0;
            for (int w = 0; w < KEY_NUM; w++)
            begin
                prog_reg[w] <= '0;
            end
        end
        else
        begin
            len_reg   <= len_next;
            term_reg  <= term_next;
            found_reg <= found_next;
            prog_reg  <= prog_next;
        end
    end

    assign status.found   = found_reg;
    assign status.dropped = ctl.fire && !ctl.eom && full;

    `ASSERT_ALWAYS(a_len_in_range, clk, rst_n, len_reg <= LIMIT)
    `ASSERT_NEXT(a_drop_holds_len, clk, rst_n, status.dropped, len_reg == $past(len_reg))
    `ASSERT_NEXT(a_eom_clears, clk, rst_n, ctl.fire && ctl.eom, len_reg == '0 && found_reg == '0)

endmodule

// File: src/ukmdc_duty.sv
// Command selection and the four duty level registers with their guarded updates.
// Depends on ukmdc_pkg.
module ukmdc_duty (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ukmdc_pkg::ctl_t                ctl,
    input  logic [ukmdc_pkg::KEY_NUM-1:0]  found,
    input  ukmdc_pkg::cfg_t                cfg,
    output ukmdc_pkg::res_t                res
);
    import ukmdc_pkg::*;

    duty_t duty_reg, duty_next;
    cmd_t  cmd;
    logic  applied;
    logic  fwd_up_ok, fwd_dn_ok, back_up_ok, back_dn_ok;

    // at end of message, the found keyword earliest in table order wins
    always_comb
    begin
        cmd = CMD_NONE;
        if (ctl.eom)
        begin
            for (int w = KEY_NUM - 1; w >= 0; w--)
            begin
                if (found[w])
                begin
                    cmd = cmd_t'(3'(w + 1));
                end
            end
        end
    end

    assign fwd_up_ok  = duty_reg[0] < cfg.upper_guard && duty_reg[2] < cfg.upper_guard;
    assign fwd_dn_ok  = duty_reg[0] > cfg.lower_guard && duty_reg[2] > cfg.lower_guard;
    assign back_up_ok = duty_reg[1] < cfg.upper_guard && duty_reg[3] < cfg.upper_guard;
    assign back_dn_ok = duty_reg[1] > cfg.lower_guard && duty_reg[3] > cfg.lower_guard;

    always_comb
    begin
        duty_next = duty_reg;
        applied   = 1'b0;
        case (cmd)
            CMD_FWD_UP:
            begin
                if (fwd_up_ok)
                begin
                    duty_next[0] = duty_reg[0] + cfg.duty_step;
                    duty_next[2] = duty_reg[2] + cfg.duty_step;
                    duty_next[1] = '0;
                    duty_next[3] = '0;
                    applied      = 1'b1;
                end
            end
            CMD_FWD_DOWN:
            begin
                if (fwd_dn_ok)
                begin
                    duty_next[0] = duty_reg[0] - cfg.duty_step;
                    duty_next[2] = duty_reg[2] - cfg.duty_step;
                    duty_next[1] = '0;
                    duty_next[3] = '0;
                    applied      = 1'b1;
                end
            end
            CMD_BACK_UP:
            begin
                if (back_up_ok)
                begin
                    duty_next[1] = duty_reg[1] + cfg.duty_step;
                    duty_next[3] = duty_reg[3] + cfg.duty_step;
                    duty_next[0] = '0;
                    duty_next[2] = '0;
                    applied      = 1'b1;
                end
            end
            CMD_BACK_DOWN:
            begin
                if (back_dn_ok)
                begin
                    duty_next[1] = duty_reg[1] - cfg.duty_step;
                    duty_next[3] = duty_reg[3] - cfg.duty_step;
                    duty_next[0] = '0;
                    duty_next[2] = '0;
                    applied      = 1'b1;
                end
            end
            CMD_STOP:
            begin
                duty_next = '0;
                applied   = 1'b1;
            end
            CMD_RIGHT:
            begin
                duty_next    = '0;
                duty_next[0] = cfg.turn_level;
                applied      = 1'b1;
            end
            CMD_LEFT:
            begin
                duty_next    = '0;
                duty_next[2] = cfg.turn_level;
                applied      = 1'b1;
            end
            default:
            begin
                duty_next = duty_reg;
            end
        endcase
    end

    assign res.command = cmd;
    assign res.applied = applied;
    assign res.duty    = duty_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            duty_reg <= '0;
        end
        else if (ctl.fire)
        begin
            duty_reg <= duty_next;
        end
    end

endmodule

// File: src/uart_keyword_motor_duty_control_top.sv
// Keyword duty controller, top level: input and result registers, config registers.
// Uses ukmdc_pkg, ukmdc_matcher, ukmdc_duty and assert_macros.svh.
//
// Input channel (in_valid / in_stall): one request per UART event. op = 0
// carries a received byte in rx_byte, op = 1 marks end of message.
// Output channel (out_valid / out_stall): exactly one result per request, in
// order: command, applied, byte_dropped and the four duty levels after it.
// Throughput is one request per clock unless out_stall holds a full result
// register. A taken request sits in the input register; its result, computed from
// the matcher and duty state, loads into the result register as it advances.
// When out_stall holds a full result register, the input register keeps its
// request and in_stall rises; nothing is lost or repeated.
// Config (cfg_we / cfg_index / cfg_data) writes one register per edge; write
// only while no request is in flight.
// Reset clears the message state and duty levels and loads the config defaults
// (step 100, upper guard 999, lower guard 100, turn level 999).
`include "assert_macros.svh"

module uart_keyword_motor_duty_control_top #(
    parameter int MSG_LIMIT = ukmdc_pkg::MSG_LIMIT_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            op,
    input  logic [ukmdc_pkg::BYTE_W-1:0]    rx_byte,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [2:0]                      command,
    output logic                            applied,
    output logic                            byte_dropped,
    output logic [ukmdc_pkg::DUTY_W-1:0]    duty_one,
    output logic [ukmdc_pkg::DUTY_W-1:0]    duty_two,
    output logic [ukmdc_pkg::DUTY_W-1:0]    duty_three,
    output logic [ukmdc_pkg::DUTY_W-1:0]    duty_four,
    input  logic                            cfg_we,
    input  logic [ukmdc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ukmdc_pkg::DUTY_W-1:0]    cfg_data
);
    import ukmdc_pkg::*;

    cfg_t              cfg_reg;
    logic              in_valid_reg;
    logic              op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_valid_reg;
    cmd_t              cmd_reg;
    logic              applied_reg;
    logic              dropped_reg;
    duty_t             duty_reg;
    logic              advance;
    logic              accept;
    ctl_t              ctl;
    match_t            status;
    res_t              res;

    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    assign ctl.fire = advance;
    assign ctl.eom  = op_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.duty_step   <= DUTY_STEP_RST;
            cfg_reg.upper_guard <= UPPER_GUARD_RST;
            cfg_reg.lower_guard <= LOWER_GUARD_RST;
            cfg_reg.turn_level  <= TURN_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                REG_DUTY_STEP:   cfg_reg.duty_step   <= cfg_data;
                REG_UPPER_GUARD: cfg_reg.upper_guard <= cfg_data;
                REG_LOWER_GUARD: cfg_reg.lower_guard <= cfg_data;
                REG_TURN_LEVEL:  cfg_reg.turn_level  <= cfg_data;
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op;
            byte_reg <= rx_byte;
        end
        if (advance)
        begin
            cmd_reg     <= res.command;
            applied_reg <= res.applied;
            dropped_reg <= status.dropped;
            duty_reg    <= res.duty;
        end
    end

    ukmdc_matcher #(
        .MSG_LIMIT (MSG_LIMIT)
    ) u_matcher (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (ctl),
        .rx_byte (byte_reg),
        .status  (status)
    );

    ukmdc_duty u_duty (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .found (status.found),
        .cfg   (cfg_reg),
        .res   (res)
    );

    assign out_valid    = out_valid_reg;
    assign command      = cmd_reg;
    assign applied      = applied_reg;
    assign byte_dropped = dropped_reg;
    assign duty_one     = duty_reg[0];
    assign duty_two     = duty_reg[1];
    assign duty_three   = duty_reg[2];
    assign duty_four    = duty_reg[3];

    `ASSERT_NEXT(a_held_request_stays, clk, rst_n, in_valid_reg && !advance, in_valid_reg)
    `ASSERT_IMPLIES(a_applied_has_cmd, clk, rst_n, out_valid_reg && applied_reg, cmd_reg != CMD_NONE)
    `ASSERT_IMPLIES(a_drop_no_cmd, clk, rst_n, out_valid_reg && dropped_reg, cmd_reg == CMD_NONE)
    `ASSERT_IMPLIES(a_stop_zeroes, clk, rst_n, out_valid_reg && cmd_reg == CMD_STOP, duty_reg == '0)

endmodule
